// File: src/fps_pkg.sv
// shared types and constants for the frame percentile selector
`timescale 1ns / 1ps
package fps_pkg;

  localparam int unsigned PctW   = 14;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CfgW   = 14;
  localparam logic [PctW-1:0] PctFull  = 14'd10000;
  localparam logic [PctW-1:0] PctReset = 14'd5000;

  // configuration register indexes
  typedef enum logic {
    CFG_PERCENTILE  = 1'b0,
    CFG_INTERPOLATE = 1'b1
  } cfg_idx_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_CMP,
    ST_PLACE,
    ST_PROD,
    ST_DIV,
    ST_RD_LO,
    ST_RD_HI,
    ST_BLEND_MUL,
    ST_BLEND_DIV,
    ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_sample;   // capture input sample and flags
    logic rd_prev;       // read entry pos-1
    logic wr_shift;      // write entry pos with read data, pos--
    logic wr_place;      // write sample at pos, count++
    logic drop;          // store full, set overflow
    logic start_prod;    // compute p*(n-1)
    logic div_start;     // start divider
    logic rd_lo;         // read floor entry
    logic rd_hi;         // read next entry
    logic start_mul;     // compute r*(hi-lo)
    logic blend_start;   // start signed divide of blend
    logic load_out;      // capture result
    logic clear_frame;   // reset count and overflow
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic pos_zero;
    logic prev_gt;
    logic full;
    logic is_last;
    logic interp;
    logic div_done;
  } stat_t;

endpackage

// File: src/fps_div.sv
// divider by 10000 through a reciprocal product, floor semantics on signed input
`timescale 1ns / 1ps
module fps_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        neg_i,     // numerator is negative
  input  logic [47:0] mag_i,     // magnitude of numerator
  output logic        done_o,
  output logic [47:0] quot_o,    // floor quotient, two's complement
  output logic [13:0] rem_o      // remainder of magnitude division
);
  // floor(2^48 / 10000): the estimate is low by at most one
  localparam logic [34:0] Recip   = 35'd28147497671;
  localparam logic [47:0] Divisor = 48'd10000;

  logic [47:0] num_q, num_d, sh_q, sh_d, q_q, q_d;
  logic [51:0] acc_q, acc_d;
  logic [13:0] r_q, r_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d;
  logic [47:0] q_est, back, diff;
  logic        corr;

  // estimate times 10000 by shifts, then one compare and subtract
  assign q_est = {12'd0, acc_q[51:16]};
  assign back  = (q_est << 13) + (q_est << 10) + (q_est << 9) + (q_est << 8) + (q_est << 4);
  assign diff  = num_q - back;
  assign corr  = (diff >= Divisor);

  // three 16-bit slices of the numerator times the reciprocal, then correction
  always_comb begin
    num_d = num_q; sh_d = sh_q; q_d = q_q; acc_d = acc_q; r_d = r_q;
    cnt_d = cnt_q; busy_d = busy_q; neg_d = neg_q;
    if (start_i) begin
      num_d = mag_i; sh_d = mag_i; acc_d = '0; cnt_d = '0; busy_d = 1'b1; neg_d = neg_i;
    end else if (busy_q) begin
      if (cnt_q != 2'd3) begin
        acc_d = (acc_q >> 16) + 52'(sh_q[15:0]) * 52'(Recip);
        sh_d  = sh_q >> 16;
        cnt_d = cnt_q + 2'd1;
      end else begin
        q_d    = corr ? q_est + 48'd1 : q_est;
        r_d    = corr ? 14'(diff - Divisor) : diff[13:0];
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d; sh_q <= sh_d; acc_q <= acc_d;
    q_q <= q_d; r_q <= r_d; neg_q <= neg_d;
  end

  // floor of negative: -(q) minus one when remainder nonzero
  assign done_o = !busy_q;
  assign rem_o  = r_q;
  assign quot_o = neg_q ? (~q_q + 48'd1 - {47'd0, (r_q != '0)}) : q_q;
endmodule

// File: src/fps_datapath.sv
// sorted sample store, position arithmetic and blend
`timescale 1ns / 1ps
module fps_datapath #(
  parameter int unsigned MaxFrame = 256,
  parameter int unsigned AddrW    = 8,
  parameter int unsigned CntW     = 9
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fps_pkg::ctrl_t       ctrl_i,
  output fps_pkg::stat_t       stat_o,
  input  logic signed [31:0]   sample_value_i,
  input  logic                 last_in_frame_i,
  input  logic [fps_pkg::PctW-1:0] pct_i,
  input  logic                 interp_i,
  output logic signed [31:0]   percentile_value_o,
  output logic                 overflow_flag_o
);
  logic signed [31:0] mem [MaxFrame];
  logic signed [31:0] rd_q, x_q, lo_q, out_q;
  logic [CntW-1:0] cnt_q, pos_q, idx_q;
  logic            ovf_q, last_q, interp_q, out_ovf_q;
  logic [47:0]     prod_q, mulres_q;
  logic            mulneg_q;
  logic [13:0]     p_clip;
  logic            div_start, div_done, div_neg;
  logic [47:0]     div_mag, div_quot;
  logic [13:0]     div_rem;
  logic [CntW-1:0] idx_calc, nm1;
  logic signed [32:0] diff;
  logic [32:0]     diff_mag;
  logic [47:0]     prod_round;
  logic            blend_small;

  assign p_clip = (pct_i > fps_pkg::PctFull) ? fps_pkg::PctFull : pct_i;
  assign nm1    = cnt_q - CntW'(1);

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_shift) mem[pos_q[AddrW-1:0]] <= rd_q;
    else if (ctrl_i.wr_place) mem[pos_q[AddrW-1:0]] <= x_q;
    if (ctrl_i.rd_prev) rd_q <= mem[AddrW'(pos_q - CntW'(1))];
    else if (ctrl_i.rd_lo) rd_q <= mem[idx_calc[AddrW-1:0]];
    else if (ctrl_i.rd_hi) rd_q <= mem[(idx_q == nm1) ? idx_q[AddrW-1:0]
                                        : AddrW'(idx_q + CntW'(1))];
  end

  // frame control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; ovf_q <= 1'b0; pos_q <= '0;
    end else begin
      if (ctrl_i.load_sample) pos_q <= cnt_q;
      else if (ctrl_i.wr_shift) pos_q <= pos_q - CntW'(1);
      if (ctrl_i.wr_place) cnt_q <= cnt_q + CntW'(1);
      if (ctrl_i.drop) ovf_q <= 1'b1;
      if (ctrl_i.clear_frame) begin
        cnt_q <= '0; ovf_q <= 1'b0;
      end
    end
  end

  // arithmetic pipeline registers
  // a negative product below 5000 leaves a numerator in (0, 5000], quotient zero
  assign blend_small = mulneg_q && (mulres_q < 48'd5000);
  assign prod_round = prod_q + 48'd5000;
  assign div_start  = ctrl_i.div_start || ctrl_i.blend_start;
  assign div_neg    = ctrl_i.blend_start ? (mulneg_q && !blend_small) : 1'b0;
  assign div_mag    = ctrl_i.blend_start ? (blend_small ? 48'd5000 - mulres_q
                                         : mulneg_q ? mulres_q - 48'd5000
                                                    : mulres_q + 48'd5000)
                                         : (interp_q ? prod_q : prod_round);
  assign idx_calc   = (div_quot >= 48'(cnt_q)) ? nm1 : div_quot[CntW-1:0];
  assign diff       = 33'(rd_q) - 33'(lo_q);
  assign diff_mag   = diff[32] ? 33'(-diff) : 33'(diff);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sample) begin
      x_q <= sample_value_i; last_q <= last_in_frame_i; interp_q <= interp_i;
    end
    if (ctrl_i.start_prod) prod_q <= 48'(p_clip) * 48'(nm1);
    if (ctrl_i.rd_lo) idx_q <= idx_calc;
    if (ctrl_i.start_mul) begin
      mulres_q <= 48'(div_rem) * 48'(diff_mag);
      mulneg_q <= diff[32];
    end
    if (ctrl_i.rd_hi) lo_q <= rd_q;
    if (ctrl_i.load_out) begin
      out_q     <= interp_q ? 32'(lo_q + div_quot[31:0]) : rd_q;
      out_ovf_q <= ovf_q;
    end
  end

  // magnitude-negated numerator: -(m) + 5000 floor = -(ceil((m-5000)/1e4))
  fps_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .neg_i(div_neg), .mag_i(div_mag),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  assign stat_o.pos_zero = (pos_q == '0);
  assign stat_o.prev_gt  = (rd_q > x_q);
  assign stat_o.full     = (cnt_q >= CntW'(MaxFrame));
  assign stat_o.is_last  = last_q;
  assign stat_o.interp   = interp_q;
  assign stat_o.div_done = div_done;
  assign percentile_value_o = out_q;
  assign overflow_flag_o    = out_ovf_q;
endmodule

// File: src/fps_ctrl.sv
// controller state machine for insertion and percentile selection
`timescale 1ns / 1ps
module fps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  fps_pkg::stat_t stat_i,
  output fps_pkg::ctrl_t ctrl_o
);
  fps_pkg::state_e state_q, state_d;
  logic started_q, started_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fps_pkg::ST_IDLE; started_q <= 1'b0;
    end else begin
      state_q <= state_d; started_q <= started_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    started_d = 1'b0;
    unique case (state_q)
      fps_pkg::ST_IDLE:
        if (in_valid_i) state_d = fps_pkg::ST_SHIFT_RD;
      fps_pkg::ST_SHIFT_RD:
        if (stat_i.full) state_d = stat_i.is_last ? fps_pkg::ST_PROD : fps_pkg::ST_IDLE;
        else if (stat_i.pos_zero) state_d = fps_pkg::ST_PLACE;
        else state_d = fps_pkg::ST_SHIFT_CMP;
      fps_pkg::ST_SHIFT_CMP:
        state_d = stat_i.prev_gt ? fps_pkg::ST_SHIFT_RD : fps_pkg::ST_PLACE;
      fps_pkg::ST_PLACE:
        state_d = stat_i.is_last ? fps_pkg::ST_PROD : fps_pkg::ST_IDLE;
      fps_pkg::ST_PROD: state_d = fps_pkg::ST_DIV;
      fps_pkg::ST_DIV: begin
        started_d = 1'b1;
        if (started_q && stat_i.div_done) state_d = fps_pkg::ST_RD_LO;
      end
      fps_pkg::ST_RD_LO: state_d = fps_pkg::ST_RD_HI;
      fps_pkg::ST_RD_HI:
        state_d = stat_i.interp ? fps_pkg::ST_BLEND_MUL : fps_pkg::ST_OUT;
      fps_pkg::ST_BLEND_MUL: state_d = fps_pkg::ST_BLEND_DIV;
      fps_pkg::ST_BLEND_DIV: begin
        started_d = 1'b1;
        if (started_q && stat_i.div_done) state_d = fps_pkg::ST_OUT;
      end
      fps_pkg::ST_OUT:
        if (!out_stall_i) state_d = fps_pkg::ST_IDLE;
      default: state_d = fps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o      = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      fps_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        ctrl_o.load_sample = in_valid_i;
      end
      fps_pkg::ST_SHIFT_RD: begin
        ctrl_o.drop = stat_i.full;
        ctrl_o.rd_prev = !stat_i.full && !stat_i.pos_zero;
      end
      fps_pkg::ST_SHIFT_CMP: ctrl_o.wr_shift = stat_i.prev_gt;
      fps_pkg::ST_PLACE:     ctrl_o.wr_place = 1'b1;
      fps_pkg::ST_PROD:      ctrl_o.start_prod = 1'b1;
      fps_pkg::ST_DIV:       ctrl_o.div_start = !started_q;
      fps_pkg::ST_RD_LO:     ctrl_o.rd_lo = 1'b1;
      fps_pkg::ST_RD_HI:     ctrl_o.rd_hi = 1'b1;
      fps_pkg::ST_BLEND_MUL: ctrl_o.start_mul = 1'b1;
      fps_pkg::ST_BLEND_DIV: begin
        ctrl_o.blend_start = !started_q;
        ctrl_o.load_out = started_q && stat_i.div_done;
      end
      fps_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        ctrl_o.clear_frame = !out_stall_i;
      end
      default: ;
    endcase
    // nearest mode: the floor entry sits in the read register now
    if (state_q == fps_pkg::ST_RD_HI && !stat_i.interp) ctrl_o.load_out = 1'b1;
  end
endmodule

// File: src/frame_percentile_select.sv
// top level of the frame percentile selector
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+--------------------------------
//  in      | in        | in_valid_i / in_stall_o    | sample_value_i, last_in_frame_i
//  out     | out       | out_valid_o / out_stall_i  | percentile_value_o, overflow_flag_o
//  cfg     | in        | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// after its accept a sample keeps the input stalled through the insertion walk
// through the single-port store, longer the more stored entries are larger than it;
// a sample that finds the store full is dropped without a walk
// a last sample then runs the product, a division by 10000, the floor read and, in
// interpolate mode, the blend product and a second division before the result
// reset clears count, overflow, position, state and configuration; store content and data registers are left undefined
// the input is stalled while a request is in work or a result waits
`timescale 1ns / 1ps
module frame_percentile_select #(
  parameter int unsigned MaxFrame = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            sample_value_i,
  input  logic                          last_in_frame_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            percentile_value_o,
  output logic                          overflow_flag_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [fps_pkg::CfgW-1:0]      cfg_data_i
);
  localparam int unsigned AddrW = $clog2(MaxFrame);
  localparam int unsigned CntW  = $clog2(MaxFrame + 1);

  logic [fps_pkg::PctW-1:0] pct_q;
  logic                     interp_q;
  fps_pkg::ctrl_t           ctrl;
  fps_pkg::stat_t           stat;
  logic in_stall, out_valid;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q <= fps_pkg::PctReset; interp_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (fps_pkg::cfg_idx_e'(cfg_index_i))
        fps_pkg::CFG_PERCENTILE:  pct_q <= cfg_data_i;
        fps_pkg::CFG_INTERPOLATE: interp_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  fps_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_valid_i), .in_stall_o(in_stall),
    .out_valid_o(out_valid), .out_stall_i(out_stall_i), .stat_i(stat), .ctrl_o(ctrl)
  );

  fps_datapath #(.MaxFrame(MaxFrame), .AddrW(AddrW), .CntW(CntW)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .sample_value_i, .last_in_frame_i, .pct_i(pct_q), .interp_i(interp_q),
    .percentile_value_o, .overflow_flag_o
  );

  assign in_stall_o  = in_stall;
  assign out_valid_o = out_valid;
endmodule
